// ===== rtl/cnpr_pkg.sv =====
// Package for the checksum-neutral prefix rewrite block.
// Holds register indexes, field constants and the configuration struct.
// No dependencies; used by every module of the block.
`default_nettype none

package cnpr_pkg;

  // Configuration port index width and register indexes
  localparam int unsigned CfgIdxW = 3;
  localparam logic [CfgIdxW-1:0] RegInsidePrefix  = 3'd0;
  localparam logic [CfgIdxW-1:0] RegOutsidePrefix = 3'd1;
  localparam logic [CfgIdxW-1:0] RegRewriteMask   = 3'd2;
  localparam logic [CfgIdxW-1:0] RegInsideLength  = 3'd3;
  localparam logic [CfgIdxW-1:0] RegOutsideLength = 3'd4;
  localparam logic [CfgIdxW-1:0] RegForwardAdjust = 3'd5;
  localparam logic [CfgIdxW-1:0] RegReverseAdjust = 3'd6;

  // Field widths
  localparam int unsigned HalfW = 64;
  localparam int unsigned WordW = 16;
  localparam int unsigned LenW  = 8;

  // Prefix length limits and the all-ones word
  localparam logic [LenW-1:0]  MaxLen     = 8'd64;
  localparam logic [LenW-1:0]  LongLen    = 8'd48;
  localparam logic [WordW-1:0] WordAllOne = 16'hffff;

  // Register file contents handed to the datapath
  typedef struct packed {
    logic [HalfW-1:0] inside_prefix;
    logic [HalfW-1:0] outside_prefix;
    logic [HalfW-1:0] rewrite_mask;
    logic [LenW-1:0]  inside_length;
    logic [LenW-1:0]  outside_length;
    logic [WordW-1:0] forward_adjust;
    logic [WordW-1:0] reverse_adjust;
  } cfg_t;

  // Translation result
  typedef struct packed {
    logic [HalfW-1:0] new_upper;
    logic [HalfW-1:0] new_lower;
    logic             rejected;
  } res_t;

endpackage

`default_nettype wire

// ===== rtl/checksum_neutral_prefix_rewrite.sv =====
// Checksum-neutral IPv6 prefix rewrite, top level.
// Instantiates cnpr_cfg_regs and cnpr_xlate; uses cnpr_pkg.
//
// Usage:
//   Input channel (in_valid_i/in_ready_o) carries one 128-bit address and
//   a direction per transfer. Output channel (out_valid_o/out_ready_i)
//   returns the rewritten address and a rejected flag, one per input.
//   The configuration channel (cfg_valid_i/cfg_ready_o) writes one register
//   per transfer, selected by cfg_index_i; it is always ready. Unknown
//   indexes are dropped. Write registers only while the block is empty.
//   Each result passes through the input register, then the result register,
//   with the rewrite logic in between.
//   Throughput: one address per cycle while the receiver keeps up.
//   When the receiver stalls, the result register holds and the input
//   register fills; the input side stalls only once both are occupied.
//   Reset clears the configuration registers to zero and empties the
//   pipeline.
`default_nettype none

module checksum_neutral_prefix_rewrite (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  // configuration
  input  wire logic                          cfg_valid_i,
  output      logic                          cfg_ready_o,
  input  wire logic [cnpr_pkg::CfgIdxW-1:0]  cfg_index_i,
  input  wire logic [cnpr_pkg::HalfW-1:0]    cfg_data_i,
  // input items
  input  wire logic                          in_valid_i,
  output      logic                          in_ready_o,
  input  wire logic [cnpr_pkg::HalfW-1:0]    addr_upper_i,
  input  wire logic [cnpr_pkg::HalfW-1:0]    addr_lower_i,
  input  wire logic                          outbound_i,
  // results
  output      logic                          out_valid_o,
  input  wire logic                          out_ready_i,
  output      logic [cnpr_pkg::HalfW-1:0]    new_upper_o,
  output      logic [cnpr_pkg::HalfW-1:0]    new_lower_o,
  output      logic                          rejected_o
);

  cnpr_pkg::cfg_t cfg;
  cnpr_pkg::res_t res;

  logic                       s1_valid_q, s1_valid_d;
  logic [cnpr_pkg::HalfW-1:0] s1_upper_q, s1_lower_q;
  logic                       s1_outbound_q;
  logic                       s2_valid_q, s2_valid_d;
  cnpr_pkg::res_t             s2_res_q;
  logic                       s2_ready, in_xfer, s2_load;

  // Register file
  assign cfg_ready_o = 1'b1;

  cnpr_cfg_regs u_cfg_regs (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .cfg_o       (cfg)
  );

  // Pipeline flow control
  assign s2_ready   = !s2_valid_q || out_ready_i;
  assign in_ready_o = !s1_valid_q || s2_ready;
  assign in_xfer    = in_valid_i && in_ready_o;
  assign s2_load    = s1_valid_q && s2_ready;
  assign s1_valid_d = in_ready_o ? in_valid_i : s1_valid_q;
  assign s2_valid_d = s2_ready ? s1_valid_q : s2_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
      s2_valid_q <= 1'b0;
    end else begin
      s1_valid_q <= s1_valid_d;
      s2_valid_q <= s2_valid_d;
    end
  end

  // Input register
  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      s1_upper_q    <= addr_upper_i;
      s1_lower_q    <= addr_lower_i;
      s1_outbound_q <= outbound_i;
    end
  end

  // Rewrite logic
  cnpr_xlate u_xlate (
    .cfg_i      (cfg),
    .upper_i    (s1_upper_q),
    .lower_i    (s1_lower_q),
    .outbound_i (s1_outbound_q),
    .res_o      (res)
  );

  // Result register
  always_ff @(posedge clk_i) begin
    if (s2_load) begin
      s2_res_q <= res;
    end
  end

  assign out_valid_o = s2_valid_q;
  assign new_upper_o = s2_res_q.new_upper;
  assign new_lower_o = s2_res_q.new_lower;
  assign rejected_o  = s2_res_q.rejected;

  // Checks
  a_ready_low_means_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> (s1_valid_q && s2_valid_q))
    else $error("input stalled with a free stage");

  a_load_gives_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s2_load |=> out_valid_o)
    else $error("loaded result not presented");

  a_short_pfx_keeps_lower: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s2_load && (cfg.inside_length <= cnpr_pkg::LongLen)
             && (cfg.outside_length <= cnpr_pkg::LongLen))
      |=> (new_lower_o == $past(s1_lower_q)))
    else $error("lower half changed for a short prefix");

endmodule

`default_nettype wire

// ===== rtl/cnpr_cfg_regs.sv =====
// Configuration register file for the prefix rewrite block.
// Depends on cnpr_pkg for register indexes and the cfg_t struct.
`default_nettype none

module cnpr_cfg_regs (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          cfg_valid_i,
  input  wire logic [cnpr_pkg::CfgIdxW-1:0]  cfg_index_i,
  input  wire logic [cnpr_pkg::HalfW-1:0]    cfg_data_i,
  output      cnpr_pkg::cfg_t                cfg_o
);

  cnpr_pkg::cfg_t cfg_q, cfg_d;

  // Decode a write transfer; unknown indexes leave everything as is
  always_comb begin
    cfg_d = cfg_q;
    if (cfg_valid_i) begin
      case (cfg_index_i)
        cnpr_pkg::RegInsidePrefix:  cfg_d.inside_prefix  = cfg_data_i;
        cnpr_pkg::RegOutsidePrefix: cfg_d.outside_prefix = cfg_data_i;
        cnpr_pkg::RegRewriteMask:   cfg_d.rewrite_mask   = cfg_data_i;
        cnpr_pkg::RegInsideLength:  cfg_d.inside_length  = cfg_data_i[cnpr_pkg::LenW-1:0];
        cnpr_pkg::RegOutsideLength: cfg_d.outside_length = cfg_data_i[cnpr_pkg::LenW-1:0];
        cnpr_pkg::RegForwardAdjust: cfg_d.forward_adjust = cfg_data_i[cnpr_pkg::WordW-1:0];
        cnpr_pkg::RegReverseAdjust: cfg_d.reverse_adjust = cfg_data_i[cnpr_pkg::WordW-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '0;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

`default_nettype wire

// ===== rtl/cnpr_xlate.sv =====
// Single-pass translation logic: prefix check, word choice, mask rewrite
// and ones' complement adjust. Depends on cnpr_pkg.
`default_nettype none

module cnpr_xlate (
  input  wire cnpr_pkg::cfg_t                cfg_i,
  input  wire logic [cnpr_pkg::HalfW-1:0]    upper_i,
  input  wire logic [cnpr_pkg::HalfW-1:0]    lower_i,
  input  wire logic                          outbound_i,
  output      cnpr_pkg::res_t                res_o
);

  localparam int unsigned NumLanes = cnpr_pkg::HalfW / cnpr_pkg::WordW;
  localparam int unsigned ShW      = $clog2(cnpr_pkg::HalfW + 1);

  logic [cnpr_pkg::HalfW-1:0]  from_pfx, to_pfx, top_mask, upper_rw;
  logic [cnpr_pkg::WordW-1:0]  adj;
  logic [cnpr_pkg::LenW-1:0]   len;
  logic [ShW-1:0]              shamt;
  logic                        len_ok, pfx_match, long_pfx, found;
  logic [$clog2(NumLanes)-1:0] sel;
  logic [cnpr_pkg::WordW-1:0]  lane [NumLanes];
  logic [cnpr_pkg::WordW-1:0]  word_in, word_out;
  logic [cnpr_pkg::WordW:0]    sum;
  logic [cnpr_pkg::WordW-1:0]  folded;
  logic                        ok;

  // Direction picks source/target prefix and adjustment
  assign from_pfx = outbound_i ? cfg_i.inside_prefix  : cfg_i.outside_prefix;
  assign to_pfx   = outbound_i ? cfg_i.outside_prefix : cfg_i.inside_prefix;
  assign adj      = outbound_i ? cfg_i.forward_adjust : cfg_i.reverse_adjust;

  // Effective prefix length and its top-bits mask
  assign len    = (cfg_i.inside_length > cfg_i.outside_length) ?
                  cfg_i.inside_length : cfg_i.outside_length;
  assign len_ok = (len <= cnpr_pkg::MaxLen);
  assign shamt  = ShW'(cnpr_pkg::MaxLen - len);
  assign top_mask = (len == '0) ? '0 : ({cnpr_pkg::HalfW{1'b1}} << shamt);
  assign pfx_match = (((upper_i ^ from_pfx) & top_mask) == '0);
  assign long_pfx  = (len > cnpr_pkg::LongLen);

  // Interface identifier lanes, word 4 in the top lane
  always_comb begin
    for (int k = 0; k < NumLanes; k++) begin
      lane[k] = lower_i[cnpr_pkg::HalfW-1-k*cnpr_pkg::WordW -: cnpr_pkg::WordW];
    end
  end

  // First lane that is not all ones
  always_comb begin
    found = 1'b0;
    sel   = '0;
    for (int k = NumLanes - 1; k >= 0; k--) begin
      if (lane[k] != cnpr_pkg::WordAllOne) begin
        found = 1'b1;
        sel   = k[$clog2(NumLanes)-1:0];
      end
    end
  end

  // Accept/reject decision
  always_comb begin
    if (!len_ok || !pfx_match) begin
      ok = 1'b0;
    end else if (long_pfx) begin
      ok = (lower_i != '0) && found;
    end else begin
      ok = (upper_i[cnpr_pkg::WordW-1:0] != cnpr_pkg::WordAllOne);
    end
  end

  // Mask rewrite of the upper half
  assign upper_rw = (upper_i & ~cfg_i.rewrite_mask) | (to_pfx & cfg_i.rewrite_mask);

  // Ones' complement add; a single end-around carry is enough here
  assign word_in  = long_pfx ? lane[sel] : upper_rw[cnpr_pkg::WordW-1:0];
  assign sum      = {1'b0, word_in} + {1'b0, adj};
  assign folded   = sum[cnpr_pkg::WordW-1:0] + {{(cnpr_pkg::WordW-1){1'b0}}, sum[cnpr_pkg::WordW]};
  assign word_out = (folded == cnpr_pkg::WordAllOne) ? '0 : folded;

  // Assemble the result
  always_comb begin
    res_o.rejected  = !ok;
    res_o.new_upper = upper_i;
    res_o.new_lower = lower_i;
    if (ok) begin
      res_o.new_upper = upper_rw;
      if (long_pfx) begin
        for (int k = 0; k < NumLanes; k++) begin
          if (sel == k[$clog2(NumLanes)-1:0]) begin
            res_o.new_lower[cnpr_pkg::HalfW-1-k*cnpr_pkg::WordW -: cnpr_pkg::WordW] = word_out;
          end
        end
      end else begin
        res_o.new_upper[cnpr_pkg::WordW-1:0] = word_out;
      end
    end
  end

endmodule

`default_nettype wire

// ===== dv/checksum_neutral_prefix_rewrite_test.sv =====
// Self-checking testbench for checksum_neutral_prefix_rewrite (NPTv6 prefix rewrite).
// Predicts each translation in SystemVerilog and checks results in order.
// Depends on cnpr_pkg and the checksum_neutral_prefix_rewrite RTL only.
`default_nettype none

module checksum_neutral_prefix_rewrite_test;

  typedef logic [cnpr_pkg::HalfW-1:0]   half_t;
  typedef logic [cnpr_pkg::WordW-1:0]   word_t;
  typedef logic [cnpr_pkg::LenW-1:0]    len_t;
  typedef logic [cnpr_pkg::CfgIdxW-1:0] idx_t;

  localparam idx_t RegNone = 3'd7;                // unmapped index, write is dropped
  localparam int unsigned SettleCycles = 4;       // idle cycles before a register write
  localparam int unsigned IdleLimit    = 2000;    // watchdog: cycles with no transfer
  localparam int unsigned HoldAt       = 700;     // results seen before the long stall
  localparam int unsigned HoldCycles   = 300;
  localparam int unsigned RandPhases   = 12;
  localparam int unsigned PhaseItems   = 140;

  typedef enum logic {XferAddr, XferCfg} xfer_kind_e;

  typedef struct {
    xfer_kind_e kind;
    half_t      upper;
    half_t      lower;
    logic       outbound;
    idx_t       index;
    half_t      data;
  } request_t;

  logic clk = 1'b0;
  logic rst_ni = 1'b0;

  logic   cfg_valid = 1'b0;
  logic   cfg_ready;
  idx_t   cfg_index = '0;
  half_t  cfg_data = '0;
  logic   in_valid = 1'b0;
  logic   in_ready;
  half_t  addr_upper = '0;
  half_t  addr_lower = '0;
  logic   outbound = 1'b0;
  logic   out_valid;
  logic   out_ready = 1'b0;
  half_t  new_upper;
  half_t  new_lower;
  logic   rejected;

  request_t       requests[$];
  cnpr_pkg::res_t due_results[$];
  cnpr_pkg::cfg_t gen_cfg;   // settings as the stimulus will see them
  cnpr_pkg::cfg_t pred_cfg;  // settings as written into the block

  logic in_fire = 1'b0;
  logic cfg_fire = 1'b0;
  int unsigned mismatches = 0;
  int unsigned results_seen = 0;
  int unsigned translated_cnt = 0;
  int unsigned rejected_cnt = 0;
  int unsigned cfg_writes = 0;
  int unsigned idle_cycles = 0;

  always #10 clk = ~clk;

  checksum_neutral_prefix_rewrite u_top (
    .clk_i        (clk),
    .rst_ni       (rst_ni),
    .cfg_valid_i  (cfg_valid),
    .cfg_ready_o  (cfg_ready),
    .cfg_index_i  (cfg_index),
    .cfg_data_i   (cfg_data),
    .in_valid_i   (in_valid),
    .in_ready_o   (in_ready),
    .addr_upper_i (addr_upper),
    .addr_lower_i (addr_lower),
    .outbound_i   (outbound),
    .out_valid_o  (out_valid),
    .out_ready_i  (out_ready),
    .new_upper_o  (new_upper),
    .new_lower_o  (new_lower),
    .rejected_o   (rejected)
  );

  // ---------------------------------------------------------------------------
  // Translation predictor
  // ---------------------------------------------------------------------------

  // Top n bits of a 64-bit half set
  function automatic half_t top_mask(len_t n);
    if (n == '0) return '0;
    if (n >= cnpr_pkg::MaxLen) return '1;
    return ~64'd0 << (64 - n);
  endfunction

  // 16-bit ones' complement add; an all-ones sum is written as zero
  function automatic word_t ones_add(word_t a, word_t b);
    logic [cnpr_pkg::WordW:0] s;
    s = {1'b0, a} + {1'b0, b};
    s = {1'b0, s[cnpr_pkg::WordW-1:0]} + s[cnpr_pkg::WordW];
    return (s[cnpr_pkg::WordW-1:0] == cnpr_pkg::WordAllOne) ? '0 : s[cnpr_pkg::WordW-1:0];
  endfunction

  function automatic cnpr_pkg::cfg_t apply_write(cnpr_pkg::cfg_t c, idx_t idx, half_t d);
    case (idx)
      cnpr_pkg::RegInsidePrefix:  c.inside_prefix  = d;
      cnpr_pkg::RegOutsidePrefix: c.outside_prefix = d;
      cnpr_pkg::RegRewriteMask:   c.rewrite_mask   = d;
      cnpr_pkg::RegInsideLength:  c.inside_length  = d[cnpr_pkg::LenW-1:0];
      cnpr_pkg::RegOutsideLength: c.outside_length = d[cnpr_pkg::LenW-1:0];
      cnpr_pkg::RegForwardAdjust: c.forward_adjust = d[cnpr_pkg::WordW-1:0];
      cnpr_pkg::RegReverseAdjust: c.reverse_adjust = d[cnpr_pkg::WordW-1:0];
      default: ;
    endcase
    return c;
  endfunction

  function automatic cnpr_pkg::res_t translate_addr(cnpr_pkg::cfg_t c, half_t up, half_t lo,
                                                    logic ob);
    half_t          from_pfx;
    half_t          to_pfx;
    word_t          adj;
    len_t           len;
    logic           ok;
    int             word;
    cnpr_pkg::res_t r;
    from_pfx = ob ? c.inside_prefix : c.outside_prefix;
    to_pfx   = ob ? c.outside_prefix : c.inside_prefix;
    adj      = ob ? c.forward_adjust : c.reverse_adjust;
    len      = (c.inside_length > c.outside_length) ? c.inside_length : c.outside_length;
    ok       = 1'b1;
    word     = 3;
    if (len > cnpr_pkg::MaxLen) begin
      ok = 1'b0;
    end else if (((up ^ from_pfx) & top_mask(len)) != '0) begin
      ok = 1'b0;
    end else if (len > cnpr_pkg::LongLen) begin
      // long prefix: first of words 4..7 that is not all ones
      if (lo == '0) begin
        ok = 1'b0;
      end else begin
        word = 8;
        for (int k = 7; k >= 4; k--) begin
          if (lo[cnpr_pkg::WordW*(7-k) +: cnpr_pkg::WordW] != cnpr_pkg::WordAllOne) word = k;
        end
        if (word == 8) ok = 1'b0;
      end
    end else if (up[cnpr_pkg::WordW-1:0] == cnpr_pkg::WordAllOne) begin
      ok = 1'b0;
    end
    // word choice is fixed above; rewrite first, then adjust
    if (ok) begin
      up = (up & ~c.rewrite_mask) | (to_pfx & c.rewrite_mask);
      if (word == 3) begin
        up[cnpr_pkg::WordW-1:0] = ones_add(up[cnpr_pkg::WordW-1:0], adj);
      end else begin
        lo[cnpr_pkg::WordW*(7-word) +: cnpr_pkg::WordW] =
          ones_add(lo[cnpr_pkg::WordW*(7-word) +: cnpr_pkg::WordW], adj);
      end
    end
    r.new_upper = up;
    r.new_lower = lo;
    r.rejected  = ~ok;
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // Stimulus generation
  // ---------------------------------------------------------------------------

  function automatic half_t rand64();
    return {$urandom, $urandom};
  endfunction

  // Idle length: mostly short, now and then long; none in a calm stretch
  function automatic int unsigned pick_gap(logic calm);
    int unsigned r;
    if (calm) return 0;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 40);
  endfunction

  function automatic len_t pick_len();
    case ($urandom_range(0, 9))
      0: return '0;
      1: return cnpr_pkg::LongLen;
      2: return cnpr_pkg::LongLen + 8'd1;
      3: return cnpr_pkg::MaxLen;
      4: return len_t'($urandom_range(65, 255));
      default: return len_t'($urandom_range(1, 64));
    endcase
  endfunction

  function automatic half_t pick_half();
    case ($urandom_range(0, 9))
      0: return '0;
      1: return '1;
      default: return rand64();
    endcase
  endfunction

  function automatic word_t pick_adj();
    case ($urandom_range(0, 9))
      0: return '0;
      1: return cnpr_pkg::WordAllOne;
      default: return word_t'($urandom_range(0, 16'hffff));
    endcase
  endfunction

  task automatic write_reg(idx_t idx, half_t d);
    request_t q;
    q.kind = XferCfg;
    q.upper = '0;
    q.lower = '0;
    q.outbound = 1'b0;
    q.index = idx;
    q.data = d;
    requests.push_back(q);
    gen_cfg = apply_write(gen_cfg, idx, d);
  endtask

  task automatic add_addr(half_t up, half_t lo, logic ob);
    request_t q;
    q.kind = XferAddr;
    q.upper = up;
    q.lower = lo;
    q.outbound = ob;
    q.index = '0;
    q.data = '0;
    requests.push_back(q);
  endtask

  // New random settings; each register is rewritten with some probability
  task automatic random_settings();
    len_t len_max;
    if ($urandom_range(0, 9) < 7) write_reg(cnpr_pkg::RegInsideLength, half_t'(pick_len()));
    if ($urandom_range(0, 9) < 7) write_reg(cnpr_pkg::RegOutsideLength, half_t'(pick_len()));
    if ($urandom_range(0, 9) < 7) write_reg(cnpr_pkg::RegInsidePrefix, pick_half());
    if ($urandom_range(0, 9) < 7) write_reg(cnpr_pkg::RegOutsidePrefix, pick_half());
    len_max = (gen_cfg.inside_length > gen_cfg.outside_length) ?
              gen_cfg.inside_length : gen_cfg.outside_length;
    if ($urandom_range(0, 9) < 7) begin
      case ($urandom_range(0, 4))
        0: write_reg(cnpr_pkg::RegRewriteMask, '0);
        1: write_reg(cnpr_pkg::RegRewriteMask, '1);
        2: write_reg(cnpr_pkg::RegRewriteMask, top_mask(len_max));
        3: write_reg(cnpr_pkg::RegRewriteMask, rand64());
        default: write_reg(cnpr_pkg::RegRewriteMask, top_mask(len_max) | 64'hffff);
      endcase
    end
    if ($urandom_range(0, 9) < 7) write_reg(cnpr_pkg::RegForwardAdjust, half_t'(pick_adj()));
    if ($urandom_range(0, 9) < 7) write_reg(cnpr_pkg::RegReverseAdjust, half_t'(pick_adj()));
    if ($urandom_range(0, 19) == 0) write_reg(RegNone, rand64());
  endtask

  // Mostly prefix-matching addresses, steered toward the word-selection corners
  task automatic random_addr();
    half_t       up;
    half_t       lo;
    half_t       from_pfx;
    half_t       keep;
    word_t       adj;
    len_t        len;
    logic        ob;
    int unsigned r;
    ob = 1'($urandom_range(0, 1));
    up = rand64();
    lo = rand64();
    from_pfx = ob ? gen_cfg.inside_prefix : gen_cfg.outside_prefix;
    adj = ob ? gen_cfg.forward_adjust : gen_cfg.reverse_adjust;
    len = (gen_cfg.inside_length > gen_cfg.outside_length) ?
          gen_cfg.inside_length : gen_cfg.outside_length;
    if ($urandom_range(0, 99) < 80 && len <= cnpr_pkg::MaxLen) begin
      keep = top_mask(len);
      up = (from_pfx & keep) | (up & ~keep);
    end
    r = $urandom_range(0, 99);
    if (r < 5) begin
      lo = '0;
    end else if (r < 15) begin
      lo = lo | (~64'd0 << (64 - 16 * $urandom_range(1, 4)));
    end else if (r < 22) begin
      up[cnpr_pkg::WordW-1:0] = cnpr_pkg::WordAllOne;
    end else if (r < 27) begin
      // sums that land on all ones
      up[cnpr_pkg::WordW-1:0] = ~adj;
      lo[cnpr_pkg::HalfW-1 -: cnpr_pkg::WordW] = ~adj;
    end
    add_addr(up, lo, ob);
  endtask

  // ---------------------------------------------------------------------------
  // Driver: one request per transfer, inputs change on the falling edge
  // ---------------------------------------------------------------------------
  always @(negedge clk) begin : send_proc
    logic        next_in;
    logic        next_cfg;
    logic        in_calm;
    int unsigned send_gap;
    int unsigned settle;
    if (rst_ni) begin
      if ($urandom_range(0, 63) == 0) in_calm = ($urandom_range(0, 2) == 0);
      if ((!in_valid || in_fire) && (!cfg_valid || cfg_fire)) begin
        next_in = 1'b0;
        next_cfg = 1'b0;
        if (send_gap != 0) begin
          send_gap--;
        end else if (requests.size() != 0) begin
          if (requests[0].kind == XferAddr) begin
            addr_upper <= requests[0].upper;
            addr_lower <= requests[0].lower;
            outbound   <= requests[0].outbound;
            next_in = 1'b1;
            void'(requests.pop_front());
            send_gap = pick_gap(in_calm);
          end else if (due_results.size() == 0 && settle >= SettleCycles) begin
            // register writes only once the pipeline has drained
            cfg_index <= requests[0].index;
            cfg_data  <= requests[0].data;
            next_cfg = 1'b1;
            void'(requests.pop_front());
            settle = 0;
          end else begin
            settle = (due_results.size() == 0) ? settle + 1 : 0;
          end
        end
        in_valid  <= next_in;
        cfg_valid <= next_cfg;
      end
    end else begin
      in_calm = 1'b0;
      send_gap = 0;
      settle = 0;
    end
  end

  // ---------------------------------------------------------------------------
  // Receiver: random stalls plus one long hold-off that backs up the input
  // ---------------------------------------------------------------------------
  always @(negedge clk) begin : recv_proc
    logic        out_calm;
    logic        hold_done;
    int unsigned hold_left;
    int unsigned stall_left;
    if (rst_ni) begin
      if ($urandom_range(0, 63) == 0) out_calm = ($urandom_range(0, 2) == 0);
      if (!hold_done && results_seen >= HoldAt) begin
        hold_done = 1'b1;
        hold_left = HoldCycles;
      end
      if (hold_left != 0) begin
        hold_left--;
        out_ready <= 1'b0;
      end else if (stall_left != 0) begin
        stall_left--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
        stall_left = pick_gap(out_calm);
      end
    end else begin
      out_calm = 1'b0;
      hold_done = 1'b0;
      hold_left = 0;
      stall_left = 0;
    end
  end

  task automatic report_mismatch(string what, half_t got, half_t want);
    $display("[%0t] result %0d %s: got %h, want %h", $time, results_seen, what, got, want);
    mismatches++;
  endtask

  // ---------------------------------------------------------------------------
  // Monitor: predicts on each input transfer, checks each output transfer
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin : watch_proc
    cnpr_pkg::res_t want;
    if (rst_ni) begin
      in_fire  <= in_valid && in_ready;
      cfg_fire <= cfg_valid && cfg_ready;
      if (cfg_valid && cfg_ready) begin
        pred_cfg = apply_write(pred_cfg, cfg_index, cfg_data);
        cfg_writes++;
      end
      if (in_valid && in_ready) begin
        due_results.push_back(translate_addr(pred_cfg, addr_upper, addr_lower, outbound));
      end
      if (out_valid && out_ready) begin
        if (due_results.size() == 0) begin
          report_mismatch("arrived with none pending, upper", new_upper, '0);
        end else begin
          want = due_results.pop_front();
          if (new_upper !== want.new_upper) report_mismatch("new_upper", new_upper, want.new_upper);
          if (new_lower !== want.new_lower) report_mismatch("new_lower", new_lower, want.new_lower);
          if (rejected !== want.rejected) begin
            report_mismatch("rejected", half_t'(rejected), half_t'(want.rejected));
          end
          if (want.rejected) rejected_cnt++;
          else translated_cnt++;
        end
        results_seen++;
      end
      // watchdog on cycles without any transfer
      if ((in_valid && in_ready) || (cfg_valid && cfg_ready) || (out_valid && out_ready)) begin
        idle_cycles = 0;
      end else begin
        idle_cycles++;
      end
      if (idle_cycles >= IdleLimit) begin
        $display("Timeout after %0d idle cycles", IdleLimit);
        $display("Mismatches found");
        $finish;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Test sequence
  // ---------------------------------------------------------------------------
  initial begin
    gen_cfg = '0;
    pred_cfg = '0;

    // reset settings: zero length matches everything, adjustments are zero
    add_addr('0, '0, 1'b0);
    add_addr('1, '1, 1'b1);                                   // word 3 all ones
    add_addr(64'h0123_4567_89ab_fffe, 64'h1, 1'b1);

    // 48-bit pair, word 3 adjusted
    write_reg(cnpr_pkg::RegInsidePrefix,  64'hfd00_1122_3344_0000);
    write_reg(cnpr_pkg::RegOutsidePrefix, 64'h2001_0db8_00aa_0000);
    write_reg(cnpr_pkg::RegRewriteMask,   64'hffff_ffff_ffff_0000);
    write_reg(cnpr_pkg::RegInsideLength,  64'd48);
    write_reg(cnpr_pkg::RegOutsideLength, 64'd40);
    write_reg(cnpr_pkg::RegForwardAdjust, 64'h1234);
    write_reg(cnpr_pkg::RegReverseAdjust, 64'hffff);
    write_reg(RegNone,                    '1);                // dropped
    add_addr(64'hfd00_1122_3344_5555, 64'h0123_4567_89ab_cdef, 1'b1);
    add_addr(64'h2001_0db8_00aa_ffff, 64'h1, 1'b0);           // word 3 all ones
    add_addr(64'h2001_0db8_00aa_0001, 64'h2, 1'b0);
    add_addr(64'hfd00_1122_3345_0000, 64'h3, 1'b1);           // prefix mismatch
    add_addr(64'hfd00_1122_3344_edcb, 64'h4, 1'b1);           // sum is all ones
    add_addr(64'hfd00_1122_3344_ff00, 64'h5, 1'b1);           // end-around carry

    // 64-bit prefix, word chosen from the interface identifier
    write_reg(cnpr_pkg::RegInsideLength,  64'd56);
    write_reg(cnpr_pkg::RegOutsideLength, 64'd64);
    write_reg(cnpr_pkg::RegRewriteMask,   '1);
    write_reg(cnpr_pkg::RegForwardAdjust, '0);
    write_reg(cnpr_pkg::RegReverseAdjust, 64'habcd);
    add_addr(64'hfd00_1122_3344_0000, '0, 1'b1);              // zero identifier
    add_addr(64'hfd00_1122_3344_0000, '1, 1'b1);              // no usable word
    add_addr(64'hfd00_1122_3344_0000, 64'hffff_0000_1234_5678, 1'b1);
    add_addr(64'h2001_0db8_00aa_0000, 64'hffff_ffff_ffff_0001, 1'b0);
    add_addr(64'h2001_0db8_00aa_0000, 64'h0000_0000_0000_0001, 1'b0);
    add_addr(64'h2001_0db8_00aa_0001, 64'h1, 1'b0);           // last prefix bit differs

    // lengths beyond 64 reject everything
    write_reg(cnpr_pkg::RegInsideLength,  64'd65);
    write_reg(cnpr_pkg::RegOutsideLength, '0);
    add_addr(64'hfd00_1122_3344_0000, 64'h1, 1'b1);
    write_reg(cnpr_pkg::RegInsideLength,  64'hff);
    add_addr(64'hfd00_1122_3344_0000, 64'h1, 1'b1);

    // 49-bit prefix, all-ones and zero prefixes
    write_reg(cnpr_pkg::RegInsideLength,  64'd49);
    write_reg(cnpr_pkg::RegInsidePrefix,  '1);
    write_reg(cnpr_pkg::RegOutsidePrefix, '0);
    write_reg(cnpr_pkg::RegRewriteMask,   '0);
    write_reg(cnpr_pkg::RegForwardAdjust, 64'hffff);
    add_addr('1, 64'h0000_0000_0000_0001, 1'b1);              // 0 + ffff folds to 0
    add_addr(64'h0000_0000_0000_7fff, 64'hffff_0001_0000_0000, 1'b0);

    // random phases
    for (int p = 0; p < RandPhases; p++) begin
      random_settings();
      for (int i = 0; i < PhaseItems; i++) random_addr();
    end

    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_ni = 1'b1;

    // drain: all requests sent and every result back
    while (requests.size() != 0 || in_valid || cfg_valid || due_results.size() != 0) begin
      @(posedge clk);
    end
    repeat (8) @(posedge clk);

    $display("Checked %0d addresses: %0d translated, %0d rejected", results_seen,
             translated_cnt, rejected_cnt);
    $display("Settings changed by %0d register writes, one long output stall", cfg_writes);
    if (mismatches == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

`default_nettype wire
